>>> hw/rtl/pbec_pkg.sv
// shared constants and item types for the polyblep edge correction pipeline
// used by every module of the block, no dependencies
package pbec_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int PHASE_BITS  = 16;
    localparam int FRAC_BITS   = SAMPLE_BITS - 3;
    localparam int QUO_BITS    = FRAC_BITS + 2;
    localparam int T_BITS      = QUO_BITS + 1;
    localparam int MAG_BITS    = PHASE_BITS + 1;
    localparam int NUM_BITS    = PHASE_BITS + 2;
    localparam int REM_BITS    = PHASE_BITS + QUO_BITS;
    localparam int SQ_BITS     = 2 * QUO_BITS;
    localparam int RES_BITS    = SAMPLE_BITS + 3;
    localparam int DIV_STAGES  = QUO_BITS;

    localparam logic [1:0] EDGE_NONE = 2'd0;
    localparam logic [1:0] EDGE_WRAP = 2'd1;

    localparam int ACT_PREV_BIT = 0;
    localparam int ACT_SAW_BIT  = 1;

    typedef struct packed {
        logic                   pass;
        logic                   falling;
        logic [SAMPLE_BITS-1:0] sample;
    } t_ctrl;

    typedef struct packed {
        t_ctrl                 ctrl;
        logic                  neg;
        logic                  zero;
        logic                  ovf;
        logic [PHASE_BITS-1:0] step;
        logic [REM_BITS-1:0]   rem;
        logic [QUO_BITS-1:0]   quo;
    } t_div;

endpackage

>>> hw/rtl/pbec_prep.sv
// operand stage: picks the numerator, takes its magnitude, flags quotient overflow
// depends on pbec_pkg
module pbec_prep (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_valid,
    input  logic [1:0]                      i_action,
    input  logic [1:0]                      i_edge_kind,
    input  logic [pbec_pkg::SAMPLE_BITS-1:0] i_sample_in,
    input  logic [pbec_pkg::PHASE_BITS-1:0]  i_phase,
    input  logic [pbec_pkg::PHASE_BITS-1:0]  i_phase_step,
    output logic                            o_valid,
    output pbec_pkg::t_div                  o_data
);

    localparam logic [pbec_pkg::NUM_BITS-1:0] HALF_PH =
        pbec_pkg::NUM_BITS'(1) << (pbec_pkg::PHASE_BITS - 1);
    localparam logic [pbec_pkg::NUM_BITS-1:0] ONE_PH =
        pbec_pkg::NUM_BITS'(1) << pbec_pkg::PHASE_BITS;

    logic                              r_valid;
    pbec_pkg::t_div                    r_data;
    pbec_pkg::t_div                    n_data;
    logic                              prev;
    logic                              saw;
    logic                              falling;
    logic [pbec_pkg::NUM_BITS-1:0]     ph_ext;
    logic [pbec_pkg::NUM_BITS-1:0]     num;
    logic [pbec_pkg::NUM_BITS-1:0]     num_abs;
    logic [pbec_pkg::MAG_BITS-1:0]     mag;
    logic [pbec_pkg::PHASE_BITS+1:0]   step4;
    logic                              zero;

    always_comb begin
        prev    = i_action[pbec_pkg::ACT_PREV_BIT];
        saw     = i_action[pbec_pkg::ACT_SAW_BIT];
        falling = !saw && (i_edge_kind != pbec_pkg::EDGE_WRAP);
        ph_ext  = {2'b00, i_phase};
        if (falling) begin
            num = ph_ext - HALF_PH;
        end else if (prev) begin
            num = ph_ext - ONE_PH;
        end else begin
            num = ph_ext;
        end
        num_abs = num[pbec_pkg::NUM_BITS-1] ? (~num + 1'b1) : num;
        mag     = num_abs[pbec_pkg::MAG_BITS-1:0];
        step4   = {i_phase_step, 2'b00};
        zero    = (mag == '0);

        n_data.ctrl.pass    = (i_edge_kind == pbec_pkg::EDGE_NONE);
        n_data.ctrl.falling = falling;
        n_data.ctrl.sample  = i_sample_in;
        n_data.neg          = num[pbec_pkg::NUM_BITS-1];
        n_data.zero         = zero;
        n_data.ovf          = !zero && ({1'b0, mag} >= step4);
        n_data.step         = i_phase_step;
        n_data.rem          = pbec_pkg::REM_BITS'(mag) << pbec_pkg::FRAC_BITS;
        n_data.quo          = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

>>> hw/rtl/pbec_div_stage.sv
// one restoring divider stage: one quotient bit per stage, remainder shifts left
// depends on pbec_pkg
module pbec_div_stage (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  pbec_pkg::t_div i_data,
    output logic           o_valid,
    output pbec_pkg::t_div o_data
);

    logic                            r_valid;
    pbec_pkg::t_div                  r_data;
    pbec_pkg::t_div                  n_data;
    logic [pbec_pkg::REM_BITS-1:0]   div_al;
    logic [pbec_pkg::REM_BITS-1:0]   diff;
    logic                            ge;

    always_comb begin
        div_al = pbec_pkg::REM_BITS'(i_data.step) << (pbec_pkg::QUO_BITS - 1);
        ge     = (i_data.rem >= div_al);
        diff   = ge ? (i_data.rem - div_al) : i_data.rem;
        n_data     = i_data;
        n_data.rem = diff << 1;
        n_data.quo = {i_data.quo[pbec_pkg::QUO_BITS-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

>>> hw/rtl/pbec_residual.sv
// back end: saturates the quotient, squares it, forms the residual and the
// saturated output sample over three register stages; depends on pbec_pkg
module pbec_residual (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  logic                             i_valid,
    input  pbec_pkg::t_div                   i_data,
    output logic                             o_valid,
    output logic [pbec_pkg::SAMPLE_BITS-1:0] o_sample_out,
    output logic                             o_clipped
);

    localparam int QB = pbec_pkg::QUO_BITS;
    localparam int RB = pbec_pkg::RES_BITS;
    localparam int HB = pbec_pkg::SQ_BITS - pbec_pkg::FRAC_BITS - 1;

    localparam logic [QB-1:0] TMAX = QB'((1 << (pbec_pkg::FRAC_BITS + 1)) - 1);
    localparam logic [QB-1:0] TNEG = QB'(1) << (pbec_pkg::FRAC_BITS + 1);
    localparam logic signed [RB-1:0] HALF = RB'(1) << (pbec_pkg::FRAC_BITS - 1);
    localparam logic signed [RB-1:0] SMAX = RB'((1 << (pbec_pkg::SAMPLE_BITS - 1)) - 1);
    localparam logic signed [RB-1:0] SMIN = -(RB'(1) << (pbec_pkg::SAMPLE_BITS - 1));

    typedef struct packed {
        pbec_pkg::t_ctrl                 ctrl;
        logic                            clip;
        logic                            tpos;
        logic [pbec_pkg::T_BITS-1:0]     t;
        logic [QB-1:0]                   tmag;
    } t_tsat;

    typedef struct packed {
        pbec_pkg::t_ctrl                 ctrl;
        logic                            clip;
        logic                            tpos;
        logic [pbec_pkg::T_BITS-1:0]     t;
        logic [pbec_pkg::SQ_BITS-1:0]    sq;
    } t_sq;

    logic                              r_valid_a;
    logic                              r_valid_b;
    logic                              r_valid_c;
    t_tsat                             r_a;
    t_tsat                             n_a;
    t_sq                               r_b;
    t_sq                               n_b;
    logic [pbec_pkg::SAMPLE_BITS-1:0]  r_sample;
    logic [pbec_pkg::SAMPLE_BITS-1:0]  n_sample;
    logic                              r_clip;
    logic                              n_clip;
    logic [pbec_pkg::T_BITS-1:0]       tmag_ext;
    logic [HB-1:0]                     hs;
    logic signed [RB-1:0]              t_x;
    logic signed [RB-1:0]              hs_x;
    logic signed [RB-1:0]              samp_x;
    logic signed [RB-1:0]              r;
    logic signed [RB-1:0]              r2;
    logic signed [RB-1:0]              res;

    // quotient saturation to [-2, 2)
    always_comb begin
        n_a.ctrl = i_data.ctrl;
        if (i_data.zero) begin
            n_a.clip = 1'b0;
            n_a.tmag = '0;
        end else if (i_data.neg) begin
            n_a.clip = i_data.ovf || (i_data.quo > TNEG);
            n_a.tmag = n_a.clip ? TNEG : i_data.quo;
        end else begin
            n_a.clip = i_data.ovf || (i_data.quo > TMAX);
            n_a.tmag = n_a.clip ? TMAX : i_data.quo;
        end
        tmag_ext = {1'b0, n_a.tmag};
        n_a.t    = i_data.neg ? (~tmag_ext + 1'b1) : tmag_ext;
        n_a.tpos = !i_data.neg && (n_a.tmag != '0);
    end

    // square of the magnitude
    always_comb begin
        n_b.ctrl = r_a.ctrl;
        n_b.clip = r_a.clip;
        n_b.tpos = r_a.tpos;
        n_b.t    = r_a.t;
        n_b.sq   = pbec_pkg::SQ_BITS'(r_a.tmag) * pbec_pkg::SQ_BITS'(r_a.tmag);
    end

    // residual, correction and output saturation
    always_comb begin
        hs     = r_b.sq[pbec_pkg::SQ_BITS-1:pbec_pkg::FRAC_BITS+1];
        t_x    = RB'($signed(r_b.t));
        hs_x   = $signed(RB'(hs));
        samp_x = RB'($signed(r_b.ctrl.sample));
        r      = r_b.tpos ? (t_x - hs_x - HALF) : (hs_x + t_x + HALF);
        r2     = r <<< 1;
        res    = r_b.ctrl.falling ? (samp_x - r2) : (samp_x + r2);
        if (r_b.ctrl.pass) begin
            n_sample = r_b.ctrl.sample;
            n_clip   = 1'b0;
        end else if (res > SMAX) begin
            n_sample = SMAX[pbec_pkg::SAMPLE_BITS-1:0];
            n_clip   = 1'b1;
        end else if (res < SMIN) begin
            n_sample = SMIN[pbec_pkg::SAMPLE_BITS-1:0];
            n_clip   = 1'b1;
        end else begin
            n_sample = res[pbec_pkg::SAMPLE_BITS-1:0];
            n_clip   = r_b.clip;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_a <= 1'b0;
            r_valid_b <= 1'b0;
            r_valid_c <= 1'b0;
        end else if (i_en) begin
            r_valid_a <= i_valid;
            r_valid_b <= r_valid_a;
            r_valid_c <= r_valid_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a      <= n_a;
            r_b      <= n_b;
            r_sample <= n_sample;
            r_clip   <= n_clip;
        end
    end

    assign o_valid      = r_valid_c;
    assign o_sample_out = r_sample;
    assign o_clipped    = r_clip;

endmodule

>>> hw/rtl/polyblep_edge_correction.sv
// Second-order polyBLEP edge correction. Each item carries a naive Q2.13
// sample, its Q0.16 phase, the phase step and the correction request; the
// result is the sample plus or minus twice the quadratic residual, saturated,
// with a clip flag; an item with no edge keeps its sample. The pipeline
// takes one item per cycle while not held; each item goes through one operand
// stage, one restoring divider stage per quotient bit, then quotient
// saturation, squaring and the final add-and-saturate. The whole pipeline
// holds while a finished item waits at the output and moves when it is taken.
// Depends on pbec_pkg, pbec_prep, pbec_div_stage and pbec_residual.
module polyblep_edge_correction (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [1:0]                       i_action,
    input  logic [1:0]                       i_edge_kind,
    input  logic [pbec_pkg::SAMPLE_BITS-1:0] i_sample_in,
    input  logic [pbec_pkg::PHASE_BITS-1:0]  i_phase,
    input  logic [pbec_pkg::PHASE_BITS-1:0]  i_phase_step,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [pbec_pkg::SAMPLE_BITS-1:0] o_sample_out,
    output logic                             o_clipped
);

    logic           en;
    logic           div_valid [pbec_pkg::DIV_STAGES+1];
    pbec_pkg::t_div div_data  [pbec_pkg::DIV_STAGES+1];

    assign en      = !o_valid || i_ready;
    assign o_ready = en;

    pbec_prep u_prep (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (en),
        .i_valid      (i_valid),
        .i_action     (i_action),
        .i_edge_kind  (i_edge_kind),
        .i_sample_in  (i_sample_in),
        .i_phase      (i_phase),
        .i_phase_step (i_phase_step),
        .o_valid      (div_valid[0]),
        .o_data       (div_data[0])
    );

    for (genvar g = 0; g < pbec_pkg::DIV_STAGES; g++) begin : g_div
        pbec_div_stage u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (div_valid[g]),
            .i_data  (div_data[g]),
            .o_valid (div_valid[g+1]),
            .o_data  (div_data[g+1])
        );
    end

    pbec_residual u_residual (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (en),
        .i_valid      (div_valid[pbec_pkg::DIV_STAGES]),
        .i_data       (div_data[pbec_pkg::DIV_STAGES]),
        .o_valid      (o_valid),
        .o_sample_out (o_sample_out),
        .o_clipped    (o_clipped)
    );

endmodule
